@@ sv/u8u16_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package u8u16_pkg;

   localparam int BYTE_W  = 8;
   localparam int UNIT_W  = 16;
   localparam int CP_W    = 21;
   localparam int REM_W   = 2;
   localparam int LEN_W   = 3;
   localparam int RSP_DEPTH = 4;
   localparam int CNT_W   = $clog2(RSP_DEPTH + 1);

   localparam logic [UNIT_W-1:0] LEAD_SURR_OFFSET = 16'hD7C0;
   localparam logic [UNIT_W-1:0] TRAIL_SURR_BASE  = 16'hDC00;
   localparam logic [CP_W-1:0]   MAX_CODE_POINT   = 21'h10FFFF;
   localparam logic [CP_W-1:0]   BMP_MAX          = 21'h00FFFF;
   localparam logic [CP_W-1:0]   TRAIL_MASK       = 21'h0003FF;
   localparam logic [CP_W-1:0]   SURR_LOW         = 21'h00D800;
   localparam logic [CP_W-1:0]   SURR_HIGH        = 21'h00DFFF;
   localparam logic [CP_W-1:0]   MIN_LEN2         = 21'h000080;
   localparam logic [CP_W-1:0]   MIN_LEN3         = 21'h000800;
   localparam logic [CP_W-1:0]   MIN_LEN4         = 21'h010000;

   localparam logic [LEN_W-1:0] SEQ_LEN1 = 3'd1;
   localparam logic [LEN_W-1:0] SEQ_LEN2 = 3'd2;
   localparam logic [LEN_W-1:0] SEQ_LEN3 = 3'd3;
   localparam logic [LEN_W-1:0] SEQ_LEN4 = 3'd4;

   typedef struct packed {
      logic [UNIT_W-1:0] code_unit;
      logic              error_flag;
      logic              last_of_run;
      logic              string_done;
   } rsp_item_type;

   function automatic logic code_point_ok(input logic [CP_W-1:0] cp,
                                          input logic [LEN_W-1:0] len);
      logic ok;
      ok = 1'b1;
      if (cp > MAX_CODE_POINT) ok = 1'b0;
      if (cp >= SURR_LOW && cp <= SURR_HIGH) ok = 1'b0;
      if (len == SEQ_LEN2 && cp < MIN_LEN2) ok = 1'b0;
      if (len == SEQ_LEN3 && cp < MIN_LEN3) ok = 1'b0;
      if (len == SEQ_LEN4 && cp < MIN_LEN4) ok = 1'b0;
      return ok;
   endfunction

endpackage

`default_nettype wire

@@ sv/u8u16_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface u8u16_req_if;
   import u8u16_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              end_of_string;

   modport source (output valid, in_byte, end_of_string, input ready);
   modport sink   (input valid, in_byte, end_of_string, output ready);
endinterface

interface u8u16_rsp_if;
   import u8u16_pkg::*;
   logic              valid;
   logic              ready;
   logic [UNIT_W-1:0] code_unit;
   logic              error_flag;
   logic              last_of_run;
   logic              string_done;

   modport source (output valid, code_unit, error_flag, last_of_run, string_done,
                   input ready);
   modport sink   (input valid, code_unit, error_flag, last_of_run, string_done,
                   output ready);
endinterface

`default_nettype wire

@@ sv/utf8_to_utf16_transcoder.sv @@
// With the result queue empty, the first code unit of a byte is on rsp in the cycle
// after the byte is taken.
// One byte per cycle is taken while rsp keeps up and req ready holds; a supplementary
// code point gives two units, which leave in turn through the four-entry result queue.
// req ready is high while at most two results wait in that queue.
// Reset (synchronous, active high) clears the decoder state and empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_utf16_transcoder (
   input  wire logic  clock,
   input  wire logic  reset,
   u8u16_req_if.sink  req_chan,
   u8u16_rsp_if.source rsp_chan
);
   import u8u16_pkg::*;

   logic [CP_W-1:0]  partial_ff, partial_in;
   logic [REM_W-1:0] remain_ff, remain_in;
   logic [LEN_W-1:0] seq_len_ff, seq_len_in;
   logic             discard_ff, discard_in;

   rsp_item_type     queue_ff [RSP_DEPTH];
   rsp_item_type     queue_in [RSP_DEPTH];
   rsp_item_type     shifted  [RSP_DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;

   logic             accept;
   logic             pop;
   logic [CNT_W-1:0] base;
   logic [1:0]       push_n;

   rsp_item_type     res0, res1;
   logic [1:0]       res_n;
   logic [LEN_W-1:0] lead_len;
   logic [CP_W-1:0]  lead_bits;
   logic [CP_W-1:0]  cp_next;
   logic [REM_W-1:0] remain_dec;
   logic [CP_W-1:0]  emit_cp;
   logic             do_emit;
   logic             do_fail;
   logic             eos;
   logic [BYTE_W-1:0] b;

   assign req_chan.ready = (count_ff <= CNT_W'(RSP_DEPTH - 2));
   assign accept         = req_chan.valid && req_chan.ready;
   assign eos            = req_chan.end_of_string;
   assign b              = req_chan.in_byte;

   // lead byte class
   always_comb begin
      lead_len  = '0;
      lead_bits = '0;
      if (b[7] == 1'b0) begin
         lead_len  = SEQ_LEN1;
         lead_bits = CP_W'(b[6:0]);
      end else if (b[7:5] == 3'b110) begin
         lead_len  = SEQ_LEN2;
         lead_bits = CP_W'(b[4:0]);
      end else if (b[7:4] == 4'b1110) begin
         lead_len  = SEQ_LEN3;
         lead_bits = CP_W'(b[3:0]);
      end else if (b[7:3] == 5'b11110) begin
         lead_len  = SEQ_LEN4;
         lead_bits = CP_W'(b[2:0]);
      end
   end

   assign cp_next    = {partial_ff[CP_W-7:0], b[5:0]};
   assign remain_dec = remain_ff - REM_W'(1);

   // decode one byte against the held sequence
   always_comb begin
      partial_in = partial_ff;
      remain_in  = remain_ff;
      seq_len_in = seq_len_ff;
      discard_in = discard_ff;
      do_emit    = 1'b0;
      do_fail    = 1'b0;
      emit_cp    = '0;
      if (accept) begin
         if (discard_ff) begin
            if (eos) discard_in = 1'b0;
         end else if (remain_ff == '0) begin
            if (lead_len == '0) begin
               do_fail = 1'b1;
            end else if (lead_len == SEQ_LEN1) begin
               do_emit = 1'b1;
               emit_cp = lead_bits;
            end else if (eos) begin
               do_fail = 1'b1;
            end else begin
               partial_in = lead_bits;
               seq_len_in = lead_len;
               remain_in  = REM_W'(lead_len - LEN_W'(1));
            end
         end else if (b[7:6] != 2'b10) begin
            do_fail = 1'b1;
         end else if (remain_dec != '0) begin
            if (eos) begin
               do_fail = 1'b1;
            end else begin
               partial_in = cp_next;
               remain_in  = remain_dec;
            end
         end else if (!code_point_ok(cp_next, seq_len_ff)) begin
            do_fail = 1'b1;
         end else begin
            do_emit = 1'b1;
            emit_cp = cp_next;
         end
         if (do_fail || do_emit) begin
            partial_in = '0;
            remain_in  = '0;
            seq_len_in = '0;
            discard_in = do_fail && !eos;
         end
      end
   end

   // build the results of this byte
   always_comb begin
      res0  = '0;
      res1  = '0;
      res_n = 2'd0;
      if (do_fail) begin
         res0.error_flag  = 1'b1;
         res0.last_of_run = 1'b1;
         res0.string_done = 1'b1;
         res_n            = 2'd1;
      end else if (do_emit) begin
         if (emit_cp > BMP_MAX) begin
            res0.code_unit   = UNIT_W'(emit_cp >> 10) + LEAD_SURR_OFFSET;
            res1.code_unit   = UNIT_W'(emit_cp & TRAIL_MASK) + TRAIL_SURR_BASE;
            res1.last_of_run = 1'b1;
            res1.string_done = eos;
            res_n            = 2'd2;
         end else begin
            res0.code_unit   = emit_cp[UNIT_W-1:0];
            res0.last_of_run = 1'b1;
            res0.string_done = eos;
            res_n            = 2'd1;
         end
      end
   end

   // result queue: advance on pop, append new results behind what remains
   assign pop    = (count_ff != '0) && rsp_chan.ready;
   assign base   = count_ff - CNT_W'(pop);
   assign push_n = res_n;

   always_comb begin
      for (int i = 0; i < RSP_DEPTH - 1; i++) begin
         shifted[i] = pop ? queue_ff[i+1] : queue_ff[i];
      end
      shifted[RSP_DEPTH-1] = queue_ff[RSP_DEPTH-1];
      for (int i = 0; i < RSP_DEPTH; i++) begin
         queue_in[i] = shifted[i];
         if (push_n != 2'd0 && base == CNT_W'(i)) queue_in[i] = res0;
         if (push_n == 2'd2 && (base + CNT_W'(1)) == CNT_W'(i)) queue_in[i] = res1;
      end
      count_in = base + CNT_W'(push_n);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         remain_ff  <= '0;
         seq_len_ff <= '0;
         discard_ff <= 1'b0;
         count_ff   <= '0;
      end else begin
         partial_ff <= partial_in;
         remain_ff  <= remain_in;
         seq_len_ff <= seq_len_in;
         discard_ff <= discard_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < RSP_DEPTH; i++) begin
         queue_ff[i] <= queue_in[i];
      end
   end

   assign rsp_chan.valid       = (count_ff != '0);
   assign rsp_chan.code_unit   = queue_ff[0].code_unit;
   assign rsp_chan.error_flag  = queue_ff[0].error_flag;
   assign rsp_chan.last_of_run = queue_ff[0].last_of_run;
   assign rsp_chan.string_done = queue_ff[0].string_done;

endmodule

`default_nettype wire
